@@ hw/rtl/cst_pkg.sv @@
// Shared types, codes and helper functions for the command slot tracker.
package cst_pkg;

	localparam int MAX_SLOTS = 32;
	localparam int SLOT_W    = $clog2(MAX_SLOTS) > 0 ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = 6;
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 2;

	// Item actions
	localparam logic [1:0] ACT_ISSUE  = 2'd0;
	localparam logic [1:0] ACT_SET    = 2'd1;
	localparam logic [1:0] ACT_SCAN   = 2'd2;
	localparam logic [1:0] ACT_RETIRE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN     = 2'd1;

	localparam logic [CNT_W-1:0]  SLOT_COUNT_RST = 6'd32;
	localparam logic [DATA_W-1:0] IRQ_EN_RST     = 32'h7800_002F;
	localparam logic [DATA_W-1:0] FATAL_BITS     = 32'h7800_0000;

	typedef struct packed {
		logic [1:0]        action;
		logic              use_ncq;
		logic [4:0]        slot_sel;
		logic [DATA_W-1:0] byte_count;
		logic [DATA_W-1:0] hw_issue_mask;
		logic [DATA_W-1:0] hw_active_mask;
		logic              task_file_err;
		logic [DATA_W-1:0] raw_irq_status;
	} in_beat_t;

	typedef struct packed {
		logic              granted;
		logic [4:0]        slot_num;
		logic [DATA_W-1:0] doorbell_mask;
		logic [DATA_W-1:0] active_set_mask;
		logic              completion_valid;
		logic              io_error;
		logic [DATA_W-1:0] byte_result;
		logic              port_error;
		logic [DATA_W-1:0] irq_ack;
		logic              last;
	} out_beat_t;

	// Update request into the slot mask unit
	typedef struct packed {
		logic        issue_en;
		logic        use_ncq;
		logic        retire_en;
		logic [4:0]  retire_slot;
	} mask_req_t;

	// Issue grant from the slot mask unit
	typedef struct packed {
		logic        ok;
		logic [4:0]  slot;
	} grant_t;

	// Lowest set bit; all-zero input gives the top slot index
	function automatic logic [4:0] lowest_bit(input logic [DATA_W-1:0] v);
		logic [4:0] idx;
		idx = 5'd31;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

	// Mask of the n lowest bits, n up to 32
	function automatic logic [DATA_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [DATA_W:0] m;
		m = ((DATA_W+1)'(1) << n) - (DATA_W+1)'(1);
		return m[DATA_W-1:0];
	endfunction

endpackage

@@ hw/rtl/command_slot_tracker_unit.sv @@
// Top level of the command slot tracker: control, config and byte-count RAM.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (cst_pkg::in_beat_t)
// out      output     out_valid / out_ready  out_data  (cst_pkg::out_beat_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Issue, set-bytes and retire are handled in the idle state; an item is taken when the
// control is idle and the output register is free or being drained.
// A scan with N completions primes with one RAM read, then gives one result per cycle
// while the output is not stalled, paced by the registered read of the byte-count RAM.
// A scan with nothing complete gives its single result without a RAM read.
// Reset clears the masks and the byte-count valid bits and loads the config defaults.
// A stalled output holds the scan; the config port is always ready.
module command_slot_tracker_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cst_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cst_pkg::out_beat_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cst_pkg::DATA_W-1:0]      cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]                  state_q;
	logic [cst_pkg::CNT_W-1:0]   slot_count_q;
	logic [cst_pkg::DATA_W-1:0]  irq_en_q;
	logic [cst_pkg::CNT_W-1:0]   eff_slots;
	logic [cst_pkg::DATA_W-1:0]  bvld_q;

	logic                        in_fire;
	logic                        out_free;
	cst_pkg::mask_req_t          mreq;
	cst_pkg::grant_t             grant;
	logic [cst_pkg::DATA_W-1:0]  done_mask;

	// Scan context
	logic [cst_pkg::DATA_W-1:0]  done_q;
	logic [cst_pkg::DATA_W-1:0]  is_q;
	logic                        perr_q;
	logic                        tferr_q;
	logic [cst_pkg::DATA_W-1:0]  scan_is;
	logic                        scan_perr;

	// RAM read stage
	logic                        rd_en;
	logic [4:0]                  rd_slot;
	logic [4:0]                  slot_s1;
	logic                        vld_s1;
	logic [cst_pkg::DATA_W-1:0]  rd_data;
	logic                        wr_en;

	cst_pkg::out_beat_t          out_q;
	logic                        out_valid_q;
	cst_pkg::out_beat_t          issue_beat;
	cst_pkg::out_beat_t          empty_beat;
	cst_pkg::out_beat_t          comp_beat;

	// Config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= cst_pkg::SLOT_COUNT_RST;
			irq_en_q     <= cst_pkg::IRQ_EN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cst_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data[cst_pkg::CNT_W-1:0];
				cst_pkg::CFG_IRQ_EN:     irq_en_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_slots = (slot_count_q > cst_pkg::CNT_W'(cst_pkg::MAX_SLOTS))
		? cst_pkg::CNT_W'(cst_pkg::MAX_SLOTS) : slot_count_q;

	// Handshakes
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Mask unit requests
	assign mreq.issue_en    = in_fire && (in_data.action == cst_pkg::ACT_ISSUE);
	assign mreq.use_ncq     = in_data.use_ncq;
	assign mreq.retire_en   = in_fire && (in_data.action == cst_pkg::ACT_RETIRE);
	assign mreq.retire_slot = in_data.slot_sel;

	cst_mask_unit u_masks (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (mreq),
		.hw_issue_mask  (in_data.hw_issue_mask),
		.hw_active_mask (in_data.hw_active_mask),
		.eff_slots      (eff_slots),
		.grant          (grant),
		.done_mask      (done_mask)
	);

	// Byte-count store; entries never written read as zero via bvld_q
	assign wr_en = in_fire && (in_data.action == cst_pkg::ACT_SET)
		&& ({1'b0, in_data.slot_sel} < eff_slots);
	assign rd_slot = cst_pkg::lowest_bit(done_q);
	assign rd_en   = (state_q == ST_READ)
		|| ((state_q == ST_LOAD) && out_free && (done_q != '0));

	cst_ram #(
		.WIDTH (cst_pkg::DATA_W),
		.DEPTH (cst_pkg::MAX_SLOTS)
	) u_bytes (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_data.slot_sel),
		.wr_data (in_data.byte_count),
		.rd_en   (rd_en),
		.rd_addr (rd_slot),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvld_q <= '0;
		end else if (wr_en) begin
			bvld_q[in_data.slot_sel] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			slot_s1 <= rd_slot;
			vld_s1  <= bvld_q[rd_slot];
		end
	end

	// Result beats
	assign scan_is   = in_data.raw_irq_status & irq_en_q;
	assign scan_perr = (scan_is & cst_pkg::FATAL_BITS) != '0;

	always_comb begin
		issue_beat                 = '0;
		issue_beat.granted         = grant.ok;
		issue_beat.slot_num        = grant.ok ? grant.slot : 5'd0;
		issue_beat.doorbell_mask   = grant.ok ? (cst_pkg::DATA_W'(1) << grant.slot) : '0;
		issue_beat.active_set_mask = (grant.ok && in_data.use_ncq)
			? (cst_pkg::DATA_W'(1) << grant.slot) : '0;
		issue_beat.last            = 1'b1;

		empty_beat            = '0;
		empty_beat.port_error = scan_perr;
		empty_beat.irq_ack    = scan_is;
		empty_beat.last       = 1'b1;

		comp_beat                  = '0;
		comp_beat.slot_num         = slot_s1;
		comp_beat.completion_valid = 1'b1;
		comp_beat.io_error         = tferr_q;
		comp_beat.byte_result      = (tferr_q || !vld_s1) ? '0 : rd_data;
		comp_beat.port_error       = perr_q;
		comp_beat.irq_ack          = is_q;
		comp_beat.last             = (done_q == '0);
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			done_q      <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (in_data.action == cst_pkg::ACT_ISSUE)) begin
						out_valid_q <= 1'b1;
					end else if (in_fire && (in_data.action == cst_pkg::ACT_SCAN)) begin
						done_q <= done_mask;
						if (done_mask == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					done_q  <= done_q & ~(cst_pkg::DATA_W'(1) << rd_slot);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (done_q != '0) begin
							done_q <= done_q & ~(cst_pkg::DATA_W'(1) << rd_slot);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire && (in_data.action == cst_pkg::ACT_ISSUE)) begin
			out_q <= issue_beat;
		end else if (in_fire && (in_data.action == cst_pkg::ACT_SCAN)) begin
			is_q    <= scan_is;
			perr_q  <= scan_perr;
			tferr_q <= in_data.task_file_err;
			out_q   <= empty_beat;
		end else if ((state_q == ST_LOAD) && out_free) begin
			out_q <= comp_beat;
		end
	end

`ifndef SYNTHESIS
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken during scan");
	a_read_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (done_q != '0))
		else $error("scan read with no completed slot");
	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.granted) |-> ($onehot(out_q.doorbell_mask)
		&& !out_q.completion_valid))
		else $error("bad issue result");
	a_scan_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && out_free && (done_q == '0)) |=> (out_valid_q && out_q.last))
		else $error("final completion not marked last");
`endif

endmodule

@@ hw/rtl/cst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hw/rtl/cst_mask_unit.sv @@
// Pending and queued slot masks: free-slot search, completion mask, updates.
module cst_mask_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cst_pkg::mask_req_t        req,
	input  logic [cst_pkg::DATA_W-1:0] hw_issue_mask,
	input  logic [cst_pkg::DATA_W-1:0] hw_active_mask,
	input  logic [cst_pkg::CNT_W-1:0]  eff_slots,
	output cst_pkg::grant_t           grant,
	output logic [cst_pkg::DATA_W-1:0] done_mask
);

	logic [cst_pkg::DATA_W-1:0] pending_q;
	logic [cst_pkg::DATA_W-1:0] queued_q;
	logic [cst_pkg::DATA_W-1:0] free_mask;
	logic [cst_pkg::DATA_W-1:0] grant_bit;
	logic [cst_pkg::DATA_W-1:0] retire_bit;

	// Free slots: clear in both snapshots and not pending, below slot count
	assign free_mask = ~(hw_active_mask | hw_issue_mask | pending_q)
		& cst_pkg::low_mask(eff_slots);
	assign grant.ok   = (free_mask != '0);
	assign grant.slot = cst_pkg::lowest_bit(free_mask);
	assign grant_bit  = cst_pkg::DATA_W'(1) << grant.slot;
	assign retire_bit = cst_pkg::DATA_W'(1) << req.retire_slot;

	// Completed: pending and clear in the snapshot that tracks the slot
	assign done_mask = (pending_q & ~queued_q & ~hw_issue_mask)
		| (pending_q & queued_q & ~hw_active_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			queued_q  <= '0;
		end else if (req.issue_en && grant.ok) begin
			pending_q <= pending_q | grant_bit;
			if (req.use_ncq) begin
				queued_q <= queued_q | grant_bit;
			end
		end else if (req.retire_en) begin
			pending_q <= pending_q & ~retire_bit;
			queued_q  <= queued_q & ~retire_bit;
		end
	end

`ifndef SYNTHESIS
	a_queued_is_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(queued_q & ~pending_q) == '0)
		else $error("queued slot not pending");
	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		grant.ok |-> ({1'b0, grant.slot} < eff_slots))
		else $error("grant beyond slot count");
	a_issue_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(req.issue_en && grant.ok) |=> pending_q[$past(grant.slot)])
		else $error("granted slot not marked pending");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for command_slot_tracker_unit: shadow slot model, directed and random beats.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 10;
	localparam int LONG_HOLD    = 120;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	cst_pkg::in_beat_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	cst_pkg::out_beat_t            out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [cst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cst_pkg::DATA_W-1:0]    cfg_data  = '0;

	// Shadow copy of the tracker registers and slot state
	logic [cst_pkg::CNT_W-1:0]  sh_slot_count = cst_pkg::SLOT_COUNT_RST;
	logic [cst_pkg::DATA_W-1:0] sh_irq_en     = cst_pkg::IRQ_EN_RST;
	logic [cst_pkg::DATA_W-1:0] sh_pending    = '0;
	logic [cst_pkg::DATA_W-1:0] sh_queued     = '0;
	logic [cst_pkg::DATA_W-1:0] sh_bytes [32];

	cst_pkg::in_beat_t  cmd_queue[$];
	cst_pkg::out_beat_t expected_results[$];

	int fail_count    = 0;
	int quiet_cycles  = 0;
	int hold_cycles   = 0;
	int send_idle_pct = 31;
	int sink_idle_pct = 31;

	command_slot_tracker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [4:0] first_set(input logic [31:0] v);
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				return 5'(i);
			end
		end
		return 5'd0;
	endfunction

	// Advance the shadow state by one accepted beat and queue the results it causes
	function automatic void predict_tracker_results(input cst_pkg::in_beat_t it);
		logic [5:0]         eff;
		logic [32:0]        span;
		logic [31:0]        free_slots;
		logic [31:0]        done;
		logic [31:0]        irq_seen;
		logic [31:0]        onehot;
		logic [4:0]         s;
		cst_pkg::out_beat_t r;
		eff = (sh_slot_count > cst_pkg::MAX_SLOTS) ? 6'(cst_pkg::MAX_SLOTS) : sh_slot_count;
		r = '0;
		case (it.action)
			cst_pkg::ACT_ISSUE: begin
				span = (33'd1 << eff) - 33'd1;
				free_slots = ~(it.hw_active_mask | it.hw_issue_mask | sh_pending) & span[31:0];
				r.last = 1'b1;
				if (free_slots != '0) begin
					s = first_set(free_slots);
					onehot = 32'd1 << s;
					sh_pending |= onehot;
					if (it.use_ncq) begin
						sh_queued |= onehot;
					end
					r.granted         = 1'b1;
					r.slot_num        = s;
					r.doorbell_mask   = onehot;
					r.active_set_mask = it.use_ncq ? onehot : '0;
				end
				expected_results.push_back(r);
			end
			cst_pkg::ACT_SET: begin
				if (it.slot_sel < eff) begin
					sh_bytes[it.slot_sel] = it.byte_count;
				end
			end
			cst_pkg::ACT_RETIRE: begin
				sh_pending[it.slot_sel] = 1'b0;
				sh_queued[it.slot_sel]  = 1'b0;
			end
			default: begin
				irq_seen = it.raw_irq_status & sh_irq_en;
				done = (sh_pending & ~sh_queued & ~it.hw_issue_mask) |
				       (sh_pending & sh_queued & ~it.hw_active_mask);
				r.port_error = |(irq_seen & cst_pkg::FATAL_BITS);
				r.irq_ack    = irq_seen;
				if (done == '0) begin
					r.last = 1'b1;
					expected_results.push_back(r);
				end
				// completed slots leave in ascending order
				while (done != '0) begin
					s = first_set(done);
					done[s] = 1'b0;
					r.slot_num         = s;
					r.completion_valid = 1'b1;
					r.io_error         = it.task_file_err;
					r.byte_result      = it.task_file_err ? '0 : sh_bytes[s];
					r.last             = (done == '0);
					expected_results.push_back(r);
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Sparse masks dominate so that slots get granted and completed
	function automatic logic [31:0] rand_mask();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom & $urandom & $urandom;
		endcase
	endfunction

	function automatic cst_pkg::in_beat_t make_item(input logic [1:0] act);
		cst_pkg::in_beat_t it;
		it.action         = act;
		it.use_ncq        = 1'($urandom_range(1));
		it.slot_sel       = $urandom_range(1) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
		it.byte_count     = $urandom;
		it.hw_issue_mask  = rand_mask();
		it.hw_active_mask = rand_mask();
		it.task_file_err  = ($urandom_range(3) == 0);
		it.raw_irq_status = $urandom;
		return it;
	endfunction

	function automatic void queue_item(input logic [1:0] act, input logic ncq,
			input logic [4:0] sel, input logic [31:0] bytes_in, input logic [31:0] ci,
			input logic [31:0] sact, input logic tfe, input logic [31:0] raw);
		cst_pkg::in_beat_t it;
		it.action         = act;
		it.use_ncq        = ncq;
		it.slot_sel       = sel;
		it.byte_count     = bytes_in;
		it.hw_issue_mask  = ci;
		it.hw_active_mask = sact;
		it.task_file_err  = tfe;
		it.raw_irq_status = raw;
		cmd_queue.push_back(it);
	endfunction

	task automatic queue_random(input int n);
		int w;
		repeat (n) begin
			w = $urandom_range(99);
			if (w < 30) begin
				cmd_queue.push_back(make_item(cst_pkg::ACT_ISSUE));
			end else if (w < 50) begin
				cmd_queue.push_back(make_item(cst_pkg::ACT_SET));
			end else if (w < 72) begin
				cmd_queue.push_back(make_item(cst_pkg::ACT_SCAN));
			end else begin
				cmd_queue.push_back(make_item(cst_pkg::ACT_RETIRE));
			end
		end
	endtask

	// Register write; the shadow copy follows at the accepting edge
	task automatic write_reg(input logic [cst_pkg::CFG_IDX_W-1:0] idx,
			input logic [cst_pkg::DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == cst_pkg::CFG_SLOT_COUNT) begin
			sh_slot_count = val[cst_pkg::CNT_W-1:0];
		end else begin
			sh_irq_en = val;
		end
	endtask

	// Everything sent and answered, then a drain wait for no-result beats to settle
	task automatic wait_idle();
		@(negedge clk);
		while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_tracker_results(in_data);
			end
			if (!in_valid || in_ready) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= cmd_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result sink with random stalls and an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		cst_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: 0x%0h", out_data);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("granted", 32'(want.granted), 32'(out_data.granted));
				check_field("slot_num", 32'(want.slot_num), 32'(out_data.slot_num));
				check_field("doorbell_mask", want.doorbell_mask, out_data.doorbell_mask);
				check_field("active_set_mask", want.active_set_mask, out_data.active_set_mask);
				check_field("completion_valid", 32'(want.completion_valid),
					32'(out_data.completion_valid));
				check_field("io_error", 32'(want.io_error), 32'(out_data.io_error));
				check_field("byte_result", want.byte_result, out_data.byte_result);
				check_field("port_error", 32'(want.port_error), 32'(out_data.port_error));
				check_field("irq_ack", want.irq_ack, out_data.irq_ack);
				check_field("last", 32'(want.last), 32'(out_data.last));
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < 32; i++) begin
			sh_bytes[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty scan, grants incl. top slot, no grant, completions, retires
		queue_item(cst_pkg::ACT_SCAN, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b1, '1);
		queue_item(cst_pkg::ACT_ISSUE, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_ISSUE, 1'b1, 5'd0, 32'h0, 32'h2, 32'h4, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_ISSUE, 1'b1, 5'd0, 32'h0, '1, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_ISSUE, 1'b0, 5'd0, 32'h0, 32'h0, 32'h7fff_ffff, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SET, 1'b0, 5'd0, '1, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SET, 1'b0, 5'd3, 32'h1234_5678, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SET, 1'b0, 5'd31, 32'h8000_0001, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SCAN, 1'b0, 5'd0, 32'h0, 32'h0, '1, 1'b0, 32'h8000_0001);
		queue_item(cst_pkg::ACT_SCAN, 1'b0, 5'd0, 32'h0, '1, 32'h0, 1'b1, 32'h4000_0000);
		queue_item(cst_pkg::ACT_RETIRE, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_RETIRE, 1'b0, 5'd5, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_RETIRE, 1'b0, 5'd3, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_RETIRE, 1'b0, 5'd31, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SCAN, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_ISSUE, 1'b1, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_RETIRE, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		wait_idle();

		// Reset configuration, random traffic
		queue_random(40);
		wait_idle();

		// One slot only, interrupts all masked
		write_reg(cst_pkg::CFG_SLOT_COUNT, 32'd1);
		write_reg(cst_pkg::CFG_IRQ_EN, 32'h0);
		@(negedge clk);
		queue_item(cst_pkg::ACT_ISSUE, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SET, 1'b0, 5'd1, '1, 32'h0, 32'h0, 1'b0, 32'h0);
		queue_item(cst_pkg::ACT_SCAN, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 1'b0, '1);
		queue_random(15);
		wait_idle();

		// No slots at all
		write_reg(cst_pkg::CFG_SLOT_COUNT, 32'd0);
		write_reg(cst_pkg::CFG_IRQ_EN, '1);
		@(negedge clk);
		queue_random(10);
		wait_idle();

		// Oversized count saturates; sink holds off so the input backs up
		write_reg(cst_pkg::CFG_SLOT_COUNT, 32'd63);
		write_reg(cst_pkg::CFG_IRQ_EN, $urandom);
		@(negedge clk);
		hold_cycles = LONG_HOLD;
		queue_random(50);
		wait_idle();

		// Full slot count, no idling on either side
		write_reg(cst_pkg::CFG_SLOT_COUNT, 32'd32);
		write_reg(cst_pkg::CFG_IRQ_EN, cst_pkg::IRQ_EN_RST);
		@(negedge clk);
		send_idle_pct = 0;
		sink_idle_pct = 0;
		queue_random(40);
		wait_idle();

		// Random partial slot count
		send_idle_pct = 31;
		sink_idle_pct = 31;
		write_reg(cst_pkg::CFG_SLOT_COUNT, 32'($urandom_range(1, 31)));
		write_reg(cst_pkg::CFG_IRQ_EN, $urandom);
		@(negedge clk);
		queue_random(40);
		wait_idle();

		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
